/* design/ccrt_pkg.sv */
// ----------------------------------------------------------------------------
// ccrt_pkg
// Shared types and codes of the column run curve tracer.
// ----------------------------------------------------------------------------
package ccrt_pkg;

    typedef enum logic [1:0] {
        KIND_NEW  = 2'd0,
        KIND_CONT = 2'd1,
        KIND_DISC = 2'd2
    } kind_t;

    // One result item on its way to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] segment_id;
        logic [15:0] column;
        logic [4:0]  row;
        logic [4:0]  prev_row;
    } result_t;

    // Byte address bit that selects the register; register 0 is the threshold.
    localparam logic REG_MIN_LEN = 1'b0;

    localparam int TDATA_OUT_W = 48;
    localparam int TDATA_IN_W  = 32;

endpackage

/* design/ccrt_lane.sv */
// ----------------------------------------------------------------------------
// ccrt_lane
// One row of the segment table being built for the current column.
// ----------------------------------------------------------------------------
module ccrt_lane #(
    parameter int LANE    = 0,
    parameter int CNT_W   = 6,
    parameter int ROW_W   = 5,
    parameter int ID_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               wr_en,
    input  logic [CNT_W-1:0]   wr_lo,
    input  logic [CNT_W-1:0]   wr_hi,
    input  logic [ID_BITS-1:0] wr_id,
    input  logic [31:0]        wr_len,
    input  logic [ROW_W-1:0]   wr_ly,
    input  logic [ID_BITS-1:0] query_id,
    output logic               seg_valid,
    output logic [ID_BITS-1:0] seg_id,
    output logic [31:0]        seg_len,
    output logic [ROW_W-1:0]   seg_ly,
    output logic               match
);

    localparam logic [CNT_W-1:0] MY_ROW = CNT_W'(LANE);

    logic               valid_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [31:0]        len_reg;
    logic [ROW_W-1:0]   ly_reg;
    logic               hit;

    // The run being written covers rows wr_lo up to but not including wr_hi.
    assign hit = wr_en && (MY_ROW >= wr_lo) && (MY_ROW < wr_hi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            id_reg  <= wr_id;
            len_reg <= wr_len;
            ly_reg  <= wr_ly;
        end
    end

    assign seg_valid = valid_reg;
    assign seg_id    = id_reg;
    assign seg_len   = len_reg;
    assign seg_ly    = ly_reg;
    assign match     = valid_reg && (id_reg == query_id);

endmodule

/* design/ccrt_out.sv */
// ----------------------------------------------------------------------------
// ccrt_out
// Output stage: a holding register that learns whether a result is the last
// of its request, followed by the stream output register.
// ----------------------------------------------------------------------------
module ccrt_out (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                gen,
    input  ccrt_pkg::result_t                   res,
    input  logic                                fin,
    output logic                                can_go,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccrt_pkg::TDATA_OUT_W-1:0]    m_tdata,  // segment_id, column, row, prev_row
    output logic [1:0]                          m_tuser,  // kind
    output logic                                m_tlast
);

    ccrt_pkg::result_t hold_reg;
    logic              hold_v_reg;
    ccrt_pkg::result_t out_reg;
    logic              out_v_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              move;

    assign out_free = !out_v_reg || m_tready;
    assign can_go   = !hold_v_reg || out_free;
    assign move     = can_go && hold_v_reg && (gen || fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (move)
            begin
                out_v_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            if (gen && can_go)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (fin && can_go)
            begin
                hold_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen && can_go)
        begin
            hold_reg <= res;
        end
        if (move)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= fin;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, out_reg.prev_row, out_reg.row, out_reg.column,
                       out_reg.segment_id};

endmodule

/* design/column_run_curve_tracer_top.sv */
// A column is worked on once its right neighbour arrives; a pass walks the run rows (with one
// extra row past the image to close the bottom run), then walks the rows again for discards,
// then commits. A final column behind a pending one costs two passes. Output stalls hold the
// walk; earlier results wait in a holding register until the next one is made, and the last
// one until the flush. A new request is taken only once the sequencer is idle again, after
// the flush of the previous request. Reset (rst_n, asynchronous, active low) clears the
// control state, the table valid bits and the threshold at once.
// ----------------------------------------------------------------------------
// column_run_curve_tracer_top
// Traces curve segments through a binary image fed one pixel column at a
// time. Per-row lanes hold the segment table of the column being built and
// search it in parallel; a sequencer walks the rows of the column.
// ----------------------------------------------------------------------------
module column_run_curve_tracer_top #(
    parameter int HEIGHT  = 32,
    parameter int ID_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ccrt_pkg::TDATA_IN_W-1:0]     s_tdata,   // column_bits
    input  logic                                s_tlast,   // is_last_column
    // Output stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccrt_pkg::TDATA_OUT_W-1:0]    m_tdata,   // segment_id, column, row, prev_row
    output logic [1:0]                          m_tuser,   // kind
    output logic                                m_tlast,   // last
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int ROW_W = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int CNT_W = $clog2(HEIGHT + 1);
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(HEIGHT - 1);
    localparam logic [CNT_W-1:0] END_ROW  = CNT_W'(HEIGHT);

    // The sequencer: idle, run walk, discard walk, commit, flush of the last result.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUNS  = 5'b00010,
        ST_DISC  = 5'b00100,
        ST_NEXT  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [31:0] min_len_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ccrt_pkg::REG_MIN_LEN) ? min_len_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 32'd0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == ccrt_pkg::REG_MIN_LEN))
        begin
            min_len_reg <= pwdata;
        end
    end

    // Column state. The input column is clipped to HEIGHT rows.
    logic [63:0]         col_wide;
    logic [HEIGHT-1:0]   col_in;
    logic [HEIGHT-1:0]   left_reg;
    logic [HEIGHT-1:0]   pending_reg;
    logic                have_pending_reg;
    logic [HEIGHT-1:0]   cur_reg;
    logic [HEIGHT-1:0]   right_reg;
    logic [HEIGHT-1:0]   in_col_reg;
    logic                second_reg;
    logic                item_last_reg;
    logic [ID_BITS-1:0]  next_id_reg;
    logic [15:0]         column_reg;

    assign col_wide = {32'd0, s_tdata};
    assign col_in   = col_wide[HEIGHT-1:0];

    // Segment table of the left column, read only at the walk row.
    logic                old_v_reg   [HEIGHT];
    logic [ID_BITS-1:0]  old_id_reg  [HEIGHT];
    logic [31:0]         old_len_reg [HEIGHT];
    logic [ROW_W-1:0]    old_ly_reg  [HEIGHT];

    // Walk registers.
    logic [CNT_W-1:0]    y_reg;
    logic                in_run_reg;
    logic [CNT_W-1:0]    ys_reg;
    logic [1:0]          cnt_l_reg;
    logic [1:0]          cnt_r_reg;
    logic                f_v_reg;
    logic [ID_BITS-1:0]  f_id_reg;
    logic [31:0]         f_len_reg;
    logic [ROW_W-1:0]    f_ly_reg;
    logic                pl_reg;
    logic                pr_reg;
    logic                p_v_reg;
    logic [ID_BITS-1:0]  p_id_reg;
    logic [31:0]         p_len_reg;
    logic [ROW_W-1:0]    p_ly_reg;

    // Values of the current walk row; rows past the image read as empty.
    logic                in_img;
    logic [ROW_W-1:0]    yi;
    logic                c_bit;
    logic                l_bit;
    logic                r_bit;
    logic                o_v;
    logic [ID_BITS-1:0]  o_id;
    logic [31:0]         o_len;
    logic [ROW_W-1:0]    o_ly;

    assign in_img = (y_reg < END_ROW);
    assign yi     = y_reg[ROW_W-1:0];
    assign c_bit  = in_img && cur_reg[yi];
    assign l_bit  = in_img && left_reg[yi];
    assign r_bit  = in_img && right_reg[yi];
    assign o_v    = in_img && old_v_reg[yi];
    assign o_id   = old_id_reg[yi];
    assign o_len  = old_len_reg[yi];
    assign o_ly   = old_ly_reg[yi];

    // Run bookkeeping. A run is closed on the row after its end, so the row
    // below it is already at hand when the branch test is made.
    logic                run_start;
    logic                run_end;
    logic                inc_l;
    logic                inc_r;
    logic [1:0]          cnt_l_next;
    logic [1:0]          cnt_r_next;
    logic                f_v_next;
    logic [ID_BITS-1:0]  f_id_next;
    logic [31:0]         f_len_next;
    logic [ROW_W-1:0]    f_ly_next;
    logic                run_ok;

    assign run_start = !in_run_reg && c_bit;
    assign run_end   = in_run_reg && !c_bit;
    assign inc_l     = run_start ? (pl_reg || l_bit) : (l_bit && !pl_reg);
    assign inc_r     = run_start ? (pr_reg || r_bit) : (r_bit && !pr_reg);

    always_comb
    begin
        if (run_start)
        begin
            cnt_l_next = {1'b0, inc_l};
            cnt_r_next = {1'b0, inc_r};
        end
        else
        begin
            cnt_l_next = (inc_l && cnt_l_reg != 2'd2) ? cnt_l_reg + 2'd1 : cnt_l_reg;
            cnt_r_next = (inc_r && cnt_r_reg != 2'd2) ? cnt_r_reg + 2'd1 : cnt_r_reg;
        end
        f_v_next   = f_v_reg;
        f_id_next  = f_id_reg;
        f_len_next = f_len_reg;
        f_ly_next  = f_ly_reg;
        if (run_start && p_v_reg)
        begin
            f_v_next   = 1'b1;
            f_id_next  = p_id_reg;
            f_len_next = p_len_reg;
            f_ly_next  = p_ly_reg;
        end
        else if ((run_start || !f_v_reg) && o_v)
        begin
            f_v_next   = 1'b1;
            f_id_next  = o_id;
            f_len_next = o_len;
            f_ly_next  = o_ly;
        end
        else if (run_start)
        begin
            f_v_next = 1'b0;
        end
    end

    assign run_ok = (cnt_l_next <= 2'd1) && (cnt_r_next <= 2'd1);

    // Midpoint and length of a closed run.
    logic [CNT_W-1:0]    ye;
    logic [CNT_W:0]      mid_sum;
    logic [ROW_W-1:0]    mid;
    logic [ROW_W-1:0]    row_delta;
    logic [2*ROW_W-1:0]  dist_sq;
    logic [32:0]         len_sum;
    logic [31:0]         len_sat;

    assign ye        = y_reg - CNT_W'(1);
    assign mid_sum   = {1'b0, ys_reg} + {1'b0, ye};
    assign mid       = mid_sum[ROW_W:1];
    assign row_delta = (f_ly_next > mid) ? f_ly_next - mid : mid - f_ly_next;
    assign dist_sq   = row_delta * row_delta;
    assign len_sum   = {1'b0, f_len_next} + 33'd1 + 33'(dist_sq);
    assign len_sat   = len_sum[32] ? 32'hFFFF_FFFF : len_sum[31:0];

    // Lanes: the new segment table, one row per lane.
    logic                lane_v   [HEIGHT];
    logic [ID_BITS-1:0]  lane_id  [HEIGHT];
    logic [31:0]         lane_len [HEIGHT];
    logic [ROW_W-1:0]    lane_ly  [HEIGHT];
    logic [HEIGHT-1:0]   lane_match;
    logic                lane_clr;
    logic                lane_wr;
    logic [ID_BITS-1:0]  wr_id;
    logic [31:0]         wr_len;
    logic                can_go;

    assign wr_id  = f_v_next ? f_id_next : next_id_reg;
    assign wr_len = f_v_next ? len_sat : 32'd0;

    genvar g;
    generate
        for (g = 0; g < HEIGHT; g++)
        begin : g_lane
            ccrt_lane #(
                .LANE    (g),
                .CNT_W   (CNT_W),
                .ROW_W   (ROW_W),
                .ID_BITS (ID_BITS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .clr       (lane_clr),
                .wr_en     (lane_wr),
                .wr_lo     (ys_reg),
                .wr_hi     (y_reg),
                .wr_id     (wr_id),
                .wr_len    (wr_len),
                .wr_ly     (mid),
                .query_id  (o_id),
                .seg_valid (lane_v[g]),
                .seg_id    (lane_id[g]),
                .seg_len   (lane_len[g]),
                .seg_ly    (lane_ly[g]),
                .match     (lane_match[g])
            );
        end
    endgenerate

    // Merge: a left segment survives if any lane carries its id on.
    logic continued;
    logic disc_emit;

    assign continued = |lane_match;
    assign disc_emit = o_v && !(p_v_reg && p_id_reg == o_id) && !continued
                       && (o_len < min_len_reg);

    // Result generation.
    logic              gen;
    logic              fin;
    ccrt_pkg::result_t res;
    logic [15:0]       id16;
    logic [31:0]       id_wide;

    always_comb
    begin
        gen     = 1'b0;
        res     = '0;
        id_wide = 32'd0;
        if (state_reg == ST_RUNS && run_end && run_ok)
        begin
            gen          = 1'b1;
            id_wide      = 32'(wr_id);
            res.kind     = f_v_next ? ccrt_pkg::KIND_CONT : ccrt_pkg::KIND_NEW;
            res.row      = 5'(mid);
            res.prev_row = f_v_next ? 5'(f_ly_next) : 5'(mid);
        end
        else if (state_reg == ST_DISC && disc_emit)
        begin
            gen          = 1'b1;
            id_wide      = 32'(o_id);
            res.kind     = ccrt_pkg::KIND_DISC;
            res.row      = 5'(o_ly);
            res.prev_row = 5'(o_ly);
        end
        id16           = id_wide[15:0];
        res.segment_id = id16;
        res.column     = column_reg;
    end

    assign fin      = (state_reg == ST_FLUSH);
    assign lane_wr  = (state_reg == ST_RUNS) && can_go && run_end && run_ok;
    assign s_tready = (state_reg == ST_IDLE);

    logic accept;
    assign accept   = s_tvalid && s_tready;
    assign lane_clr = (accept && (have_pending_reg || s_tlast))
                      || (state_reg == ST_NEXT && second_reg);

    ccrt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .gen      (gen),
        .res      (res),
        .fin      (fin),
        .can_go   (can_go),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            have_pending_reg <= 1'b0;
            next_id_reg      <= '0;
            column_reg       <= 16'd0;
            left_reg         <= '0;
            pending_reg      <= '0;
            in_run_reg       <= 1'b0;
            second_reg       <= 1'b0;
            item_last_reg    <= 1'b0;
            y_reg            <= '0;
            for (int i = 0; i < HEIGHT; i++)
            begin
                old_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_last_reg <= s_tlast;
                        in_col_reg    <= col_in;
                        y_reg         <= '0;
                        in_run_reg    <= 1'b0;
                        pl_reg        <= 1'b0;
                        pr_reg        <= 1'b0;
                        p_v_reg       <= 1'b0;
                        if (have_pending_reg)
                        begin
                            cur_reg     <= pending_reg;
                            right_reg   <= col_in;
                            second_reg  <= s_tlast;
                            pending_reg <= col_in;
                            state_reg   <= ST_RUNS;
                        end
                        else if (s_tlast)
                        begin
                            cur_reg    <= col_in;
                            right_reg  <= '0;
                            second_reg <= 1'b0;
                            state_reg  <= ST_RUNS;
                        end
                        else
                        begin
                            pending_reg      <= col_in;
                            have_pending_reg <= 1'b1;
                            state_reg        <= ST_FLUSH;
                        end
                    end
                end
                ST_RUNS:
                begin
                    if (can_go)
                    begin
                        pl_reg    <= l_bit;
                        pr_reg    <= r_bit;
                        p_v_reg   <= o_v;
                        p_id_reg  <= o_id;
                        p_len_reg <= o_len;
                        p_ly_reg  <= o_ly;
                        cnt_l_reg <= cnt_l_next;
                        cnt_r_reg <= cnt_r_next;
                        f_v_reg   <= f_v_next;
                        f_id_reg  <= f_id_next;
                        f_len_reg <= f_len_next;
                        f_ly_reg  <= f_ly_next;
                        if (run_start)
                        begin
                            in_run_reg <= 1'b1;
                            ys_reg     <= y_reg;
                        end
                        else if (run_end)
                        begin
                            in_run_reg <= 1'b0;
                            if (run_ok && !f_v_next)
                            begin
                                next_id_reg <= next_id_reg + ID_BITS'(1);
                            end
                        end
                        if (y_reg == END_ROW)
                        begin
                            y_reg     <= '0;
                            p_v_reg   <= 1'b0;
                            state_reg <= ST_DISC;
                        end
                        else
                        begin
                            y_reg <= y_reg + CNT_W'(1);
                        end
                    end
                end
                ST_DISC:
                begin
                    if (can_go)
                    begin
                        p_v_reg  <= o_v;
                        p_id_reg <= o_id;
                        if (y_reg == LAST_ROW)
                        begin
                            state_reg <= ST_NEXT;
                        end
                        else
                        begin
                            y_reg <= y_reg + CNT_W'(1);
                        end
                    end
                end
                ST_NEXT:
                begin
                    left_reg   <= cur_reg;
                    column_reg <= column_reg + 16'd1;
                    for (int i = 0; i < HEIGHT; i++)
                    begin
                        old_v_reg[i] <= lane_v[i];
                    end
                    if (second_reg)
                    begin
                        cur_reg    <= in_col_reg;
                        right_reg  <= '0;
                        second_reg <= 1'b0;
                        y_reg      <= '0;
                        in_run_reg <= 1'b0;
                        pl_reg     <= 1'b0;
                        pr_reg     <= 1'b0;
                        p_v_reg    <= 1'b0;
                        state_reg  <= ST_RUNS;
                    end
                    else
                    begin
                        if (item_last_reg)
                        begin
                            // End of image: everything but the threshold starts afresh.
                            left_reg         <= '0;
                            pending_reg      <= '0;
                            have_pending_reg <= 1'b0;
                            next_id_reg      <= '0;
                            column_reg       <= 16'd0;
                            for (int i = 0; i < HEIGHT; i++)
                            begin
                                old_v_reg[i] <= 1'b0;
                            end
                        end
                        else
                        begin
                            have_pending_reg <= 1'b1;
                        end
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    if (can_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Table payload is copied on commit and needs no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_NEXT)
        begin
            for (int i = 0; i < HEIGHT; i++)
            begin
                old_id_reg[i]  <= lane_id[i];
                old_len_reg[i] <= lane_len[i];
                old_ly_reg[i]  <= lane_ly[i];
            end
        end
    end

`ifndef SYNTHESIS
    // The walk never runs past the extra row used to close the bottom run.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUNS) |-> (y_reg <= END_ROW))
        else $error("walk row beyond image");

    // Every accepted request leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // A run is always closed before the run walk ends.
    a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
        in_run_reg |-> (state_reg == ST_RUNS))
        else $error("open run outside run walk");

    // Lanes are only written during the run walk.
    a_lane_write: assert property (@(posedge clk) disable iff (!rst_n)
        lane_wr |-> (state_reg == ST_RUNS && y_reg != '0))
        else $error("lane write outside run walk");
`endif

endmodule
